// ----- rtl/pmftl_pkg.sv -----
// ----------------------------------------------------------------------------
// pmftl_pkg
// Shared types and codes of the page-mapped flash translation layer.
// ----------------------------------------------------------------------------
package pmftl_pkg;

  localparam int MAX_BW = 6;
  localparam int MAX_CW = 6;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_INVAL = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_READ  = 3'd0,
    KIND_PROG  = 3'd1,
    KIND_MOVE  = 3'd2,
    KIND_ERASE = 3'd3,
    KIND_FULL  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    PTR_NONE   = 2'd0,
    PTR_ACTIVE = 2'd1,
    PTR_FULL   = 2'd2
  } ptr_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_UNMAP,
    S_ALLOC,
    S_SCAN,
    S_PICK,
    S_CL_RD,
    S_CL_CHK,
    S_CL_ZERO,
    S_ERASE,
    S_GCEND,
    S_PROG
  } state_e;

  typedef struct packed {
    logic       v;
    logic [6:0] lba;
  } rm_ent_t;

  typedef struct packed {
    logic [MAX_BW-1:0] m1;
    logic [MAX_BW-1:0] m2;
    logic [MAX_CW-1:0] s1;
    logic [MAX_CW-1:0] s2;
  } pick_t;

endpackage

// ----- rtl/pmftl_scan.sv -----
// ----------------------------------------------------------------------------
// pmftl_scan
// Walks the block valid counts once and keeps the two emptiest blocks.
// ----------------------------------------------------------------------------
module pmftl_scan #(
  parameter int PAGES_PER_BLOCK = 16,
  parameter int PHYSICAL_BLOCKS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [$clog2(PHYSICAL_BLOCKS)-1:0]  wb_i,
  input  logic [$clog2(PAGES_PER_BLOCK+1)-1:0] cnt_i,
  output logic [$clog2(PHYSICAL_BLOCKS)-1:0]  idx_o,
  output logic                                done_o,
  output pmftl_pkg::pick_t                    pick_o
);

  localparam int BW = $clog2(PHYSICAL_BLOCKS);

  logic [BW-1:0]          idx_q, idx_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  pmftl_pkg::pick_t       pick_q, pick_d;
  logic [pmftl_pkg::MAX_CW-1:0] c;

  assign c = pmftl_pkg::MAX_CW'(cnt_i);

  always_comb begin
    idx_d  = idx_q;
    busy_d = busy_q;
    done_d = 1'b0;
    pick_d = pick_q;
    if (start_i) begin
      idx_d     = '0;
      busy_d    = 1'b1;
      pick_d.s1 = pmftl_pkg::MAX_CW'(PAGES_PER_BLOCK + 1);
      pick_d.s2 = pmftl_pkg::MAX_CW'(PAGES_PER_BLOCK + 1);
      pick_d.m1 = '0;
      pick_d.m2 = pmftl_pkg::MAX_BW'(1);
    end else if (busy_q) begin
      if (idx_q != wb_i) begin
        if (c < pick_q.s1) begin
          pick_d.m2 = pick_q.m1;
          pick_d.s2 = pick_q.s1;
          pick_d.m1 = pmftl_pkg::MAX_BW'(idx_q);
          pick_d.s1 = c;
        end else if (c < pick_q.s2) begin
          pick_d.m2 = pmftl_pkg::MAX_BW'(idx_q);
          pick_d.s2 = c;
        end
      end
      if (idx_q == BW'(PHYSICAL_BLOCKS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    pick_q <= pick_d;
  end

  assign idx_o  = idx_q;
  assign done_o = done_q;
  assign pick_o = pick_q;

endmodule

// ----- rtl/page_mapped_ftl_with_greedy_gc.sv -----
// ----------------------------------------------------------------------------
// page_mapped_ftl_with_greedy_gc
// Page-mapped flash translation layer with greedy garbage collection.
//
//   channel   dir  tdata (low bit up)                               tlast
//   s_axis    in   command[1:0] lba[8:2]                            -
//   m_axis    out  kind[2:0] mapped[3] block[7:4] page[11:8]
//                  src_block[15:12] src_page[19:16]                 last
//
// The logical and reverse map memories are read through a register.
// Garbage collection scans the block valid counts, picks its victims,
// then reads, checks and clears each page of each cleaned block before
// erasing it. After reset a clearing pass over max(logical, physical
// pages) map entries runs before the first word is accepted. A full
// output register stalls the sequencer in whichever state wants to emit.
// ----------------------------------------------------------------------------
module page_mapped_ftl_with_greedy_gc #(
  parameter int PAGES_PER_BLOCK = 16,
  parameter int PHYSICAL_BLOCKS = 16,
  parameter int LOGICAL_BLOCKS  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // command, lba
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // kind, mapped, block, page, src_block, src_page
  output logic        m_axis_tlast
);

  localparam int LPAGES = LOGICAL_BLOCKS * PAGES_PER_BLOCK;
  localparam int PPAGES = PHYSICAL_BLOCKS * PAGES_PER_BLOCK;
  localparam int LAW    = $clog2(LPAGES);
  localparam int PAW    = $clog2(PPAGES);
  localparam int BW     = $clog2(PHYSICAL_BLOCKS);
  localparam int PW     = $clog2(PAGES_PER_BLOCK);
  localparam int WPW    = $clog2(PAGES_PER_BLOCK + 1);
  localparam int FCW    = $clog2(PHYSICAL_BLOCKS + 1);
  localparam int TW     = FCW + 1;
  localparam int CLRN   = (LPAGES > PPAGES) ? LPAGES : PPAGES;
  localparam int CLW    = $clog2(CLRN);

  typedef struct packed {
    logic          v;
    logic [BW-1:0] blk;
    logic [PW-1:0] pg;
  } lm_ent_t;

  function automatic logic [PAW-1:0] phys(input logic [BW-1:0] b, input logic [PW-1:0] p);
    return PAW'(PAW'(b) * PAW'(PAGES_PER_BLOCK) + PAW'(p));
  endfunction

  pmftl_pkg::state_e state_q, state_d;
  pmftl_pkg::ptr_e   status_q, status_d;
  pmftl_pkg::cmd_e   cmd_q;
  logic [6:0]        lba_q;
  lm_ent_t           ent_q;
  logic [BW-1:0]     wb_q, wb_d;
  logic [WPW-1:0]    wp_q, wp_d;
  logic [FCW-1:0]    fc_q, fc_d;
  logic [BW-1:0]     head_q, head_d;
  logic [BW-1:0]     cl_blk_q, cl_blk_d;
  logic [PW-1:0]     cl_pg_q, cl_pg_d;
  logic              gc_two_q, gc_two_d;
  logic              moved_q, moved_d;
  logic [CLW-1:0]    clr_q, clr_d;

  logic [BW-1:0]     fq_q [PHYSICAL_BLOCKS];
  logic [WPW-1:0]    bvc_q [PHYSICAL_BLOCKS];

  lm_ent_t                  lm_mem [LPAGES];
  pmftl_pkg::rm_ent_t       rm_mem [PPAGES];
  lm_ent_t                  lm_rdata_q, lm_wdata;
  pmftl_pkg::rm_ent_t       rm_rdata_q, rm_wdata;
  logic [LAW-1:0]           lm_raddr, lm_waddr;
  logic [PAW-1:0]           rm_raddr, rm_waddr;
  logic                     lm_we, rm_we;

  logic                     bvc_we;
  logic [BW-1:0]            bvc_widx, bvc_ridx;
  logic [WPW-1:0]           bvc_wdata, bvc_rd;

  logic                     fq_we;
  logic [BW-1:0]            fq_widx;
  logic [TW-1:0]            tail_sum;

  logic                     take, scan_start, scan_done;
  logic [BW-1:0]            scan_idx;
  pmftl_pkg::pick_t         pick;

  logic                     out_valid_q, out_last_q, out_free;
  logic [23:0]              out_data_q;
  logic                     emit_req, emit_go, emit_last, emit_mapped;
  pmftl_pkg::kind_e         emit_kind;
  logic [3:0]               emit_blk, emit_pg, emit_sblk, emit_spg;

  logic                     accept, lba_in, full_now, need_new;
  logic [PAW-1:0]           cl_src;

  assign out_free  = !out_valid_q || m_axis_tready;
  assign emit_go   = emit_req && out_free;
  assign s_axis_tready = (state_q == pmftl_pkg::S_IDLE);
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign lba_in    = (32'(lba_q) < LPAGES);
  assign bvc_rd    = bvc_q[bvc_ridx];
  assign cl_src    = phys(cl_blk_q, cl_pg_q);
  assign full_now  = (status_q == pmftl_pkg::PTR_FULL) ||
                     (status_q == pmftl_pkg::PTR_NONE && fc_q == '0) ||
                     (status_q == pmftl_pkg::PTR_ACTIVE && fc_q == '0 &&
                      32'(wp_q) + 1 >= PAGES_PER_BLOCK);
  assign need_new  = (status_q == pmftl_pkg::PTR_NONE) ||
                     (32'(wp_q) + 1 >= PAGES_PER_BLOCK);
  assign tail_sum  = TW'(head_q) + TW'(fc_q);
  assign fq_widx   = (tail_sum >= TW'(PHYSICAL_BLOCKS)) ?
                     BW'(tail_sum - TW'(PHYSICAL_BLOCKS)) : BW'(tail_sum);

  pmftl_scan #(
    .PAGES_PER_BLOCK(PAGES_PER_BLOCK),
    .PHYSICAL_BLOCKS(PHYSICAL_BLOCKS)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(scan_start),
    .wb_i   (wb_q),
    .cnt_i  (bvc_rd),
    .idx_o  (scan_idx),
    .done_o (scan_done),
    .pick_o (pick)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pmftl_pkg::S_CLEAR: begin
        if (clr_q == CLW'(CLRN - 1)) state_d = pmftl_pkg::S_IDLE;
      end
      pmftl_pkg::S_IDLE: begin
        if (accept) state_d = pmftl_pkg::S_LOOK;
      end
      pmftl_pkg::S_LOOK: begin
        unique case (cmd_q)
          pmftl_pkg::CMD_READ:  if (out_free) state_d = pmftl_pkg::S_IDLE;
          pmftl_pkg::CMD_INVAL: state_d = lba_in ? pmftl_pkg::S_UNMAP : pmftl_pkg::S_IDLE;
          pmftl_pkg::CMD_WRITE: begin
            if (!lba_in) state_d = pmftl_pkg::S_IDLE;
            else if (full_now) begin
              if (out_free) state_d = pmftl_pkg::S_IDLE;
            end else state_d = pmftl_pkg::S_UNMAP;
          end
          default: state_d = pmftl_pkg::S_IDLE;
        endcase
      end
      pmftl_pkg::S_UNMAP: begin
        state_d = (cmd_q == pmftl_pkg::CMD_WRITE) ? pmftl_pkg::S_ALLOC : pmftl_pkg::S_IDLE;
      end
      pmftl_pkg::S_ALLOC: begin
        state_d = (need_new && status_q != pmftl_pkg::PTR_NONE && fc_q == FCW'(1)) ?
                  pmftl_pkg::S_SCAN : pmftl_pkg::S_PROG;
      end
      pmftl_pkg::S_SCAN: begin
        if (scan_done) state_d = pmftl_pkg::S_PICK;
      end
      pmftl_pkg::S_PICK: begin
        state_d = (32'(pick.s1) >= PAGES_PER_BLOCK) ? pmftl_pkg::S_GCEND : pmftl_pkg::S_CL_RD;
      end
      pmftl_pkg::S_CL_RD:  state_d = pmftl_pkg::S_CL_CHK;
      pmftl_pkg::S_CL_CHK: begin
        if (!(rm_rdata_q.v && 32'(wp_q) < PAGES_PER_BLOCK) || out_free)
          state_d = pmftl_pkg::S_CL_ZERO;
      end
      pmftl_pkg::S_CL_ZERO: begin
        state_d = (cl_pg_q == PW'(PAGES_PER_BLOCK - 1)) ? pmftl_pkg::S_ERASE :
                  pmftl_pkg::S_CL_RD;
      end
      pmftl_pkg::S_ERASE: begin
        if (out_free) state_d = gc_two_q ? pmftl_pkg::S_CL_RD : pmftl_pkg::S_GCEND;
      end
      pmftl_pkg::S_GCEND: state_d = pmftl_pkg::S_PROG;
      pmftl_pkg::S_PROG: begin
        if (out_free) state_d = pmftl_pkg::S_IDLE;
      end
      default: state_d = pmftl_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    status_d  = status_q;
    wb_d      = wb_q;
    wp_d      = wp_q;
    fc_d      = fc_q;
    head_d    = head_q;
    cl_blk_d  = cl_blk_q;
    cl_pg_d   = cl_pg_q;
    gc_two_d  = gc_two_q;
    moved_d   = moved_q;
    clr_d     = clr_q;
    take      = 1'b0;
    scan_start = 1'b0;
    lm_raddr  = LAW'(lba_q);
    rm_raddr  = cl_src;
    lm_we     = 1'b0;
    lm_waddr  = LAW'(lba_q);
    lm_wdata  = '0;
    rm_we     = 1'b0;
    rm_waddr  = cl_src;
    rm_wdata  = '0;
    bvc_ridx  = wb_q;
    bvc_we    = 1'b0;
    bvc_widx  = wb_q;
    bvc_wdata = bvc_rd + 1'b1;
    fq_we     = 1'b0;
    emit_req  = 1'b0;
    emit_kind = pmftl_pkg::KIND_READ;
    emit_mapped = 1'b0;
    emit_blk  = '0;
    emit_pg   = '0;
    emit_sblk = '0;
    emit_spg  = '0;
    emit_last = 1'b0;
    unique case (state_q)
      pmftl_pkg::S_CLEAR: begin
        clr_d    = clr_q + 1'b1;
        lm_we    = (32'(clr_q) < LPAGES);
        lm_waddr = LAW'(clr_q);
        rm_we    = (32'(clr_q) < PPAGES);
        rm_waddr = PAW'(clr_q);
      end
      pmftl_pkg::S_IDLE: begin
        lm_raddr = LAW'(s_axis_tdata[8:2]);
      end
      pmftl_pkg::S_LOOK: begin
        rm_raddr = phys(lm_rdata_q.blk, lm_rdata_q.pg);
        if (cmd_q == pmftl_pkg::CMD_READ) begin
          emit_req  = 1'b1;
          emit_last = 1'b1;
          if (lba_in && lm_rdata_q.v) begin
            emit_mapped = 1'b1;
            emit_blk    = 4'(lm_rdata_q.blk);
            emit_pg     = 4'(lm_rdata_q.pg);
          end
        end else if (cmd_q == pmftl_pkg::CMD_WRITE && lba_in && full_now) begin
          emit_req  = 1'b1;
          emit_kind = pmftl_pkg::KIND_FULL;
          emit_last = 1'b1;
          if (out_free) status_d = pmftl_pkg::PTR_FULL;
        end
      end
      pmftl_pkg::S_UNMAP: begin
        bvc_ridx = ent_q.blk;
        lm_we    = 1'b1;
        rm_we    = ent_q.v;
        rm_waddr = phys(ent_q.blk, ent_q.pg);
        if (ent_q.v && rm_rdata_q.v && bvc_rd != '0) begin
          bvc_we    = 1'b1;
          bvc_widx  = ent_q.blk;
          bvc_wdata = bvc_rd - 1'b1;
        end
      end
      pmftl_pkg::S_ALLOC: begin
        if (need_new) begin
          take       = 1'b1;
          scan_start = (status_q != pmftl_pkg::PTR_NONE) && (fc_q == FCW'(1));
        end else begin
          wp_d = wp_q + 1'b1;
        end
      end
      pmftl_pkg::S_SCAN: begin
        bvc_ridx = scan_idx;
      end
      pmftl_pkg::S_PICK: begin
        cl_pg_d = '0;
        if (32'(pick.s1) + 32'(pick.s2) <= PAGES_PER_BLOCK) begin
          cl_blk_d = BW'(pick.m2);
          gc_two_d = 1'b1;
        end else begin
          cl_blk_d = BW'(pick.m1);
          gc_two_d = 1'b0;
        end
      end
      pmftl_pkg::S_CL_RD: ;
      pmftl_pkg::S_CL_CHK: begin
        moved_d = 1'b0;
        if (rm_rdata_q.v && 32'(wp_q) < PAGES_PER_BLOCK) begin
          emit_req  = 1'b1;
          emit_kind = pmftl_pkg::KIND_MOVE;
          emit_blk  = 4'(wb_q);
          emit_pg   = 4'(wp_q);
          emit_sblk = 4'(cl_blk_q);
          emit_spg  = 4'(cl_pg_q);
          if (out_free) begin
            moved_d  = 1'b1;
            rm_we    = 1'b1;
            rm_waddr = phys(wb_q, PW'(wp_q));
            rm_wdata = rm_rdata_q;
            lm_we    = (32'(rm_rdata_q.lba) < LPAGES);
            lm_waddr = LAW'(rm_rdata_q.lba);
            lm_wdata = '{v: 1'b1, blk: wb_q, pg: PW'(wp_q)};
            bvc_we   = 1'b1;
          end
        end
      end
      pmftl_pkg::S_CL_ZERO: begin
        rm_we = 1'b1;
        if (moved_q) wp_d = wp_q + 1'b1;
        cl_pg_d = cl_pg_q + 1'b1;
      end
      pmftl_pkg::S_ERASE: begin
        emit_req  = 1'b1;
        emit_kind = pmftl_pkg::KIND_ERASE;
        emit_blk  = 4'(cl_blk_q);
        if (out_free) begin
          bvc_we    = 1'b1;
          bvc_widx  = cl_blk_q;
          bvc_wdata = '0;
          if (32'(fc_q) < PHYSICAL_BLOCKS) begin
            fq_we = 1'b1;
            fc_d  = fc_q + 1'b1;
          end
          if (gc_two_q) begin
            gc_two_d = 1'b0;
            cl_blk_d = BW'(pick.m1);
            cl_pg_d  = '0;
          end
        end
      end
      pmftl_pkg::S_GCEND: begin
        take = (32'(wp_q) >= PAGES_PER_BLOCK) && (fc_q != '0);
      end
      pmftl_pkg::S_PROG: begin
        emit_req  = 1'b1;
        emit_last = 1'b1;
        if (32'(wp_q) >= PAGES_PER_BLOCK) begin
          emit_kind = pmftl_pkg::KIND_FULL;
          if (out_free) status_d = pmftl_pkg::PTR_FULL;
        end else begin
          emit_kind = pmftl_pkg::KIND_PROG;
          emit_blk  = 4'(wb_q);
          emit_pg   = 4'(wp_q);
          if (out_free) begin
            lm_we    = 1'b1;
            lm_wdata = '{v: 1'b1, blk: wb_q, pg: PW'(wp_q)};
            rm_we    = 1'b1;
            rm_waddr = phys(wb_q, PW'(wp_q));
            rm_wdata = '{v: 1'b1, lba: lba_q};
            bvc_we   = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (take) begin
      wb_d     = fq_q[head_q];
      head_d   = (head_q == BW'(PHYSICAL_BLOCKS - 1)) ? '0 : head_q + 1'b1;
      fc_d     = fc_q - 1'b1;
      wp_d     = '0;
      status_d = pmftl_pkg::PTR_ACTIVE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lm_we) lm_mem[lm_waddr] <= lm_wdata;
    lm_rdata_q <= lm_mem[lm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rm_we) rm_mem[rm_waddr] <= rm_wdata;
    rm_rdata_q <= rm_mem[rm_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PHYSICAL_BLOCKS; i++) begin
        fq_q[i]  <= BW'(i);
        bvc_q[i] <= '0;
      end
    end else begin
      if (fq_we) fq_q[fq_widx] <= cl_blk_q;
      if (bvc_we) bvc_q[bvc_widx] <= bvc_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pmftl_pkg::S_CLEAR;
      status_q    <= pmftl_pkg::PTR_NONE;
      wb_q        <= '0;
      wp_q        <= '0;
      fc_q        <= FCW'(PHYSICAL_BLOCKS);
      head_q      <= '0;
      gc_two_q    <= 1'b0;
      moved_q     <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      wb_q     <= wb_d;
      wp_q     <= wp_d;
      fc_q     <= fc_d;
      head_q   <= head_d;
      gc_two_q <= gc_two_d;
      moved_q  <= moved_d;
      clr_q    <= clr_d;
      if (emit_go) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cl_blk_q <= cl_blk_d;
    cl_pg_q  <= cl_pg_d;
    if (accept) begin
      cmd_q <= pmftl_pkg::cmd_e'(s_axis_tdata[1:0]);
      lba_q <= s_axis_tdata[8:2];
    end
    if (state_q == pmftl_pkg::S_LOOK) ent_q <= lm_rdata_q;
    if (emit_go) begin
      out_data_q <= {4'b0, emit_spg, emit_sblk, emit_pg, emit_blk, emit_mapped, emit_kind};
      out_last_q <= emit_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
  a_fc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fc_q) <= PHYSICAL_BLOCKS)
    else $error("free count above block count");
  a_pick_not_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_done |-> (BW'(pick.m1) != wb_q) && (BW'(pick.m2) != wb_q))
    else $error("victim is the write block");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bvc_we |-> 32'(bvc_wdata) <= PAGES_PER_BLOCK)
    else $error("block valid count overflow");
  a_emit_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_req && !out_free) |=> $stable(out_data_q))
    else $error("result overwritten while stalled");
`endif

endmodule

// ----- tb/page_mapped_ftl_with_greedy_gc_checker.sv -----
// ----------------------------------------------------------------------------
// page_mapped_ftl_with_greedy_gc_checker
// Watches both stream channels of the translation layer, keeps its own copy
// of the maps, counts, free queue and write pointer, predicts every output
// word of each accepted command and compares the words in order.
// ----------------------------------------------------------------------------
module page_mapped_ftl_with_greedy_gc_checker #(
  parameter int PPB = 16,
  parameter int PB  = 16,
  parameter int LB  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LP = LB * PPB;
  localparam int PP = PB * PPB;

  typedef struct packed {
    logic             last;
    logic [3:0]       src_page;
    logic [3:0]       src_block;
    logic [3:0]       page;
    logic [3:0]       block;
    logic             mapped;
    pmftl_pkg::kind_e kind;
  } word_t;

  word_t words_due[$];

  bit              lmap_v[LP];
  int              lmap_p[LP];
  bit              rmap_v[PP];
  int              rmap_l[PP];
  bit              pvalid[PP];
  int              bcount[PB];
  int              fqueue[PB];
  int              nfree;
  int              wblk;
  int              wpg;
  pmftl_pkg::ptr_e pstat;

  task automatic report(input string what, input word_t got, input word_t want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors_o++;
  endtask

  function automatic void push_word(pmftl_pkg::kind_e k, bit m, int b, int p, int sb, int sp);
    word_t w;
    w = '0;
    w.kind = k; w.mapped = m; w.block = b[3:0]; w.page = p[3:0];
    w.src_block = sb[3:0]; w.src_page = sp[3:0];
    words_due.push_back(w);
  endfunction

  function automatic void unmap(int lba);
    int p;
    if (lmap_v[lba]) begin
      p = lmap_p[lba];
      if (pvalid[p]) begin
        pvalid[p] = 0;
        if (bcount[p / PPB] > 0) bcount[p / PPB]--;
      end
      rmap_v[p] = 0;
    end
    lmap_v[lba] = 0;
  endfunction

  function automatic void open_block();
    wblk = fqueue[0] % PB;
    for (int i = 1; i < PB; i++) fqueue[i-1] = fqueue[i];
    if (nfree > 0) nfree--;
    wpg = 0;
    pstat = pmftl_pkg::PTR_ACTIVE;
  endfunction

  function automatic void clean(int b);
    int s, d;
    for (int i = 0; i < PPB; i++) begin
      s = b * PPB + i;
      if (pvalid[s] && wpg < PPB) begin
        d = wblk * PPB + wpg;
        if (rmap_v[s]) begin
          lmap_v[rmap_l[s]] = 1;
          lmap_p[rmap_l[s]] = d;
        end
        rmap_v[d] = rmap_v[s]; rmap_l[d] = rmap_l[s];
        rmap_v[s] = 0;
        pvalid[s] = 0;
        pvalid[d] = 1;
        bcount[wblk]++;
        push_word(pmftl_pkg::KIND_MOVE, 0, wblk, wpg, b, i);
        wpg++;
      end
    end
    for (int i = 0; i < PPB; i++) begin
      pvalid[b*PPB+i] = 0;
      rmap_v[b*PPB+i] = 0;
    end
    bcount[b] = 0;
    if (nfree < PB) begin
      fqueue[nfree] = b;
      nfree++;
    end
    push_word(pmftl_pkg::KIND_ERASE, 0, b, 0, 0, 0);
  endfunction

  function automatic void collect();
    int s1, s2, m1, m2, c;
    s1 = PPB + 1; s2 = PPB + 1; m1 = 0; m2 = 1;
    for (int i = 0; i < PB; i++) begin
      c = bcount[i];
      if (i != wblk) begin
        if (c < s1) begin
          m2 = m1; s2 = s1; m1 = i; s1 = c;
        end else if (c < s2) begin
          m2 = i; s2 = c;
        end
      end
    end
    if (bcount[m1] >= PPB) return;
    if (bcount[m1] + bcount[m2] <= PPB) clean(m2);
    clean(m1);
    if (wpg >= PPB && nfree > 0) open_block();
  endfunction

  function automatic void predict_command(pmftl_pkg::cmd_e cmd, int lba);
    int n0, p;
    n0 = words_due.size();
    if (cmd == pmftl_pkg::CMD_READ) begin
      if (lba < LP && lmap_v[lba]) push_word(pmftl_pkg::KIND_READ, 1, lmap_p[lba] / PPB,
                                             lmap_p[lba] % PPB, 0, 0);
      else push_word(pmftl_pkg::KIND_READ, 0, 0, 0, 0, 0);
    end else if (cmd == pmftl_pkg::CMD_INVAL) begin
      if (lba < LP) unmap(lba);
    end else if (cmd == pmftl_pkg::CMD_WRITE && lba < LP) begin
      if (pstat == pmftl_pkg::PTR_FULL || (pstat == pmftl_pkg::PTR_NONE && nfree == 0) ||
          (pstat == pmftl_pkg::PTR_ACTIVE && wpg + 1 >= PPB && nfree == 0)) begin
        pstat = pmftl_pkg::PTR_FULL;
        push_word(pmftl_pkg::KIND_FULL, 0, 0, 0, 0, 0);
      end else begin
        unmap(lba);
        if (pstat == pmftl_pkg::PTR_NONE) open_block();
        else begin
          wpg++;
          if (wpg >= PPB) begin
            open_block();
            if (nfree == 0) collect();
          end
        end
        if (wpg >= PPB) begin
          pstat = pmftl_pkg::PTR_FULL;
          push_word(pmftl_pkg::KIND_FULL, 0, 0, 0, 0, 0);
        end else begin
          p = wblk * PPB + wpg;
          pvalid[p] = 1;
          bcount[wblk]++;
          lmap_v[lba] = 1; lmap_p[lba] = p;
          rmap_v[p] = 1; rmap_l[p] = lba;
          push_word(pmftl_pkg::KIND_PROG, 0, wblk, wpg, 0, 0);
        end
      end
    end
    if (words_due.size() > n0) words_due[words_due.size()-1].last = 1;
  endfunction

  initial begin
    errors_o = 0;
    pending_o = 0;
    for (int i = 0; i < PB; i++) begin
      fqueue[i] = i;
      bcount[i] = 0;
    end
    nfree = PB; wblk = 0; wpg = 0; pstat = pmftl_pkg::PTR_NONE;
  end

  always @(posedge clk_i) begin
    word_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tlast, m_axis_tdata[19:0]};
        if (words_due.size() == 0) report("unexpected word", got, '0);
        else begin
          want = words_due.pop_front();
          if (got.kind != want.kind) report("kind", got, want);
          else if (got.mapped != want.mapped) report("mapped", got, want);
          else if (got.block != want.block) report("block", got, want);
          else if (got.page != want.page) report("page", got, want);
          else if (got.src_block != want.src_block) report("src_block", got, want);
          else if (got.src_page != want.src_page) report("src_page", got, want);
          else if (got.last != want.last) report("last", got, want);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_command(pmftl_pkg::cmd_e'(s_axis_tdata[1:0]), int'(s_axis_tdata[8:2]));
      pending_o = words_due.size();
    end
  end
endmodule

// ----- tb/page_mapped_ftl_with_greedy_gc_test.sv -----
// ----------------------------------------------------------------------------
// page_mapped_ftl_with_greedy_gc_test
// Drives commands into the translation layer: a directed opening, then
// random writes, reads, invalidates and no-ops that fill the device, force
// garbage collection and finally run it full, under several idle/stall mixes.
// ----------------------------------------------------------------------------
module page_mapped_ftl_with_greedy_gc_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  int          errors;
  int          pending;
  int          idle_pct = 0;
  int          stall_pct = 0;

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  page_mapped_ftl_with_greedy_gc u_dut (.*);

  page_mapped_ftl_with_greedy_gc_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_command(input pmftl_pkg::cmd_e cmd, input int lba);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {7'd0, lba[6:0], cmd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  function automatic pmftl_pkg::cmd_e pick_cmd();
    int r;
    r = $urandom_range(99);
    if (r < 70) return pmftl_pkg::CMD_WRITE;
    if (r < 85) return pmftl_pkg::CMD_READ;
    if (r < 95) return pmftl_pkg::CMD_INVAL;
    return pmftl_pkg::CMD_NOP;
  endfunction

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int lba;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    send_command(pmftl_pkg::CMD_READ, 0);
    send_command(pmftl_pkg::CMD_READ, 127);
    send_command(pmftl_pkg::CMD_INVAL, 5);
    send_command(pmftl_pkg::CMD_WRITE, 0);
    send_command(pmftl_pkg::CMD_WRITE, 127);
    send_command(pmftl_pkg::CMD_WRITE, 127);
    send_command(pmftl_pkg::CMD_WRITE, 0);
    send_command(pmftl_pkg::CMD_READ, 0);
    send_command(pmftl_pkg::CMD_INVAL, 0);
    send_command(pmftl_pkg::CMD_READ, 0);
    send_command(pmftl_pkg::CMD_INVAL, 127);
    send_command(pmftl_pkg::CMD_NOP, 85);
    send_command(pmftl_pkg::CMD_READ, 42);
    send_command(pmftl_pkg::CMD_WRITE, 42);
    send_command(pmftl_pkg::CMD_READ, 42);
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 64; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 64; end
        3: begin idle_pct = 34; stall_pct = 34; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      for (int i = 0; i < 40; i++) begin
        lba = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(40);
        send_command(pick_cmd(), lba);
      end
    end
    // Drive the device into garbage collection and then to full.
    idle_pct = 10; stall_pct = 20;
    for (int i = 0; i < 100; i++) send_command(pmftl_pkg::CMD_WRITE, $urandom_range(127));
    for (int i = 0; i < 5; i++) send_command(pmftl_pkg::CMD_READ, $urandom_range(127));
    s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/pmftl_pkg.sv
rtl/pmftl_scan.sv
rtl/page_mapped_ftl_with_greedy_gc.sv
tb/page_mapped_ftl_with_greedy_gc_checker.sv
tb/page_mapped_ftl_with_greedy_gc_test.sv
